// ----- src/wfhf_pkg.sv -----
package wfhf_pkg;

    // default saturation point of the byte counter
    localparam int MAX_FRAME_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int LEN_W      = 13;
    localparam int FILT_W     = 13;
    localparam int MAC_W      = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FILTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BSSID       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST        = 3'd5;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 13'd0;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 13'd4096;

    // header layout
    localparam logic [5:0] HDR_LEN_3ADDR = 6'd24;
    localparam logic [5:0] HDR_LEN_4ADDR = 6'd30;
    localparam logic [5:0] QOS_EXTRA     = 6'd2;
    localparam logic [5:0] IV_FLAG_OFS   = 6'd3;
    localparam logic [1:0] FC_TYPE_DATA  = 2'd2;
    localparam logic [1:0] DS_WDS        = 2'd3;
    localparam int         QOS_BIT       = 7;
    localparam int         EXT_IV_BIT    = 5;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic             pass;
        logic [LEN_W-1:0] frame_length;
    } t_out;

    typedef struct packed {
        logic [LEN_W-1:0]  min_length;
        logic [LEN_W-1:0]  max_length;
        logic [FILT_W-1:0] header_field_filter;
        logic [MAC_W-1:0]  bssid_filter;
        logic [MAC_W-1:0]  source_filter;
        logic [MAC_W-1:0]  dest_filter;
    } t_cfg;

    typedef struct packed {
        logic [4:0] ob;
        logic [4:0] os;
        logic [4:0] od;
    } t_offs;

    // address offsets selected by ToDS/FromDS
    function automatic t_offs addr_offsets(input logic [1:0] ds);
        t_offs o;
        unique case (ds)
            2'd0: o = '{ob: 5'd16, os: 5'd10, od: 5'd4};
            2'd1: o = '{ob: 5'd4,  os: 5'd10, od: 5'd16};
            2'd2: o = '{ob: 5'd10, os: 5'd16, od: 5'd4};
            default: o = '{ob: 5'd10, os: 5'd24, od: 5'd16};
        endcase
        return o;
    endfunction

    function automatic logic [5:0] header_len(input logic [15:0] fc);
        logic [5:0] z;
        z = (fc[9:8] == DS_WDS) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR;
        if (fc[QOS_BIT]) begin
            z = z + QOS_EXTRA;
        end
        return z;
    endfunction

    // byte k of an address filter, first byte most significant
    function automatic logic [7:0] filt_byte(input logic [MAC_W-1:0] f, input logic [2:0] k);
        logic [7:0] r;
        unique case (k)
            3'd0: r = f[47:40];
            3'd1: r = f[39:32];
            3'd2: r = f[31:24];
            3'd3: r = f[23:16];
            3'd4: r = f[15:8];
            3'd5: r = f[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- src/wfhf_cfg_regs.sv -----
module wfhf_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wfhf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wfhf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output wfhf_pkg::t_cfg                     o_cfg
);
    import wfhf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length          <= MIN_LENGTH_RST;
            r_cfg.max_length          <= MAX_LENGTH_RST;
            r_cfg.header_field_filter <= '0;
            r_cfg.bssid_filter        <= '0;
            r_cfg.source_filter       <= '0;
            r_cfg.dest_filter         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_LENGTH: r_cfg.min_length          <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_LENGTH: r_cfg.max_length          <= i_cfg_data[LEN_W-1:0];
                CFG_HDR_FILTER: r_cfg.header_field_filter <= i_cfg_data[FILT_W-1:0];
                CFG_BSSID:      r_cfg.bssid_filter        <= i_cfg_data[MAC_W-1:0];
                CFG_SOURCE:     r_cfg.source_filter       <= i_cfg_data[MAC_W-1:0];
                CFG_DEST:       r_cfg.dest_filter         <= i_cfg_data[MAC_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/wfhf_hdr_track.sv -----
module wfhf_hdr_track #(
    parameter int MAX_FRAME = wfhf_pkg::MAX_FRAME_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  wfhf_pkg::t_in  i_item,
    input  wfhf_pkg::t_cfg i_cfg,
    output logic           o_res_valid,
    output wfhf_pkg::t_out o_res
);
    import wfhf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam int EFF_W = 18;

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_fc, n_fc;
    logic             r_bssid_ok, n_bssid_ok;
    logic             r_src_ok, n_src_ok;
    logic             r_dst_ok, n_dst_ok;
    logic             r_ext_iv, n_ext_iv;

    logic             take;
    logic [15:0]      fc_new;
    t_offs            offs;
    logic [5:0]       hlen;
    logic [2:0]       ns, nd;
    logic             miss_b, miss_s, miss_d;
    logic             ok_b, ok_s, ok_d, ext_iv;
    logic [CNT_W-1:0] cnt_new;
    logic [3:0]       ext_len;
    logic signed [EFF_W-1:0] eff;
    logic [FILT_W-1:0] f;
    logic             pass;
    logic [31:0]      cnt32;

    // true when the byte at idx falls inside the window and differs from the filter
    function automatic logic win_miss(input logic [CNT_W-1:0] idx, input logic [4:0] base,
                                      input logic [2:0] n, input logic [MAC_W-1:0] flt,
                                      input logic [7:0] b);
        logic [CNT_W-1:0] k;
        logic             hit;
        k   = idx - CNT_W'(base);
        hit = (idx >= CNT_W'(base)) && (idx < CNT_W'(base) + CNT_W'(n));
        return hit && (filt_byte(flt, k[2:0]) != b);
    endfunction

    // bytes that never arrived read as zero: any nonzero filter byte there misses
    function automatic logic fill_miss(input logic [CNT_W-1:0] cnt, input logic [4:0] base,
                                       input logic [2:0] n, input logic [MAC_W-1:0] flt);
        logic m;
        m = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if ((3'(k) < n) && (CNT_W'(base) + CNT_W'(k) >= cnt)
                    && (filt_byte(flt, 3'(k)) != 8'h00)) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

    always_comb begin
        take   = r_count < CNT_MAX;
        fc_new = r_fc;
        if (take && r_count == '0) begin
            fc_new[7:0] = i_item.frame_byte;
        end else if (take && r_count == CNT_W'(1)) begin
            fc_new[15:8] = i_item.frame_byte;
        end
        offs = addr_offsets(fc_new[9:8]);
        hlen = header_len(fc_new);
        ns   = (i_cfg.source_filter == i_cfg.bssid_filter) ? 3'd5 : 3'd6;
        nd   = (i_cfg.dest_filter == i_cfg.bssid_filter) ? 3'd5 : 3'd6;

        miss_b = take && win_miss(r_count, offs.ob, 3'd6, i_cfg.bssid_filter,
                                  i_item.frame_byte);
        miss_s = take && win_miss(r_count, offs.os, ns, i_cfg.source_filter,
                                  i_item.frame_byte);
        miss_d = take && win_miss(r_count, offs.od, nd, i_cfg.dest_filter,
                                  i_item.frame_byte);
        ok_b   = r_bssid_ok && !miss_b;
        ok_s   = r_src_ok && !miss_s;
        ok_d   = r_dst_ok && !miss_d;
        ext_iv = r_ext_iv || (take && r_count >= CNT_W'(2)
                 && r_count == CNT_W'(hlen + IV_FLAG_OFS)
                 && i_item.frame_byte[EXT_IV_BIT]);
        cnt_new = take ? r_count + CNT_W'(1) : r_count;

        // verdict on the last byte
        f       = i_cfg.header_field_filter;
        ext_len = (fc_new[3:2] == FC_TYPE_DATA) ? 4'(hlen - HDR_LEN_3ADDR) : 4'd0;
        eff     = $signed(EFF_W'(cnt_new)) - $signed(EFF_W'(ext_len));
        pass    = 1'b1;
        if (eff < $signed(EFF_W'(i_cfg.min_length))
                || eff > $signed(EFF_W'(i_cfg.max_length))) begin
            pass = 1'b0;
        end
        if (f[0] && fc_new[3:2] != f[2:1]) begin
            pass = 1'b0;
        end
        if (f[3] && fc_new[6:4] != f[6:4]) begin
            pass = 1'b0;
        end
        if (f[7] && fc_new[8] != f[8]) begin
            pass = 1'b0;
        end
        if (f[9] && fc_new[9] != f[10]) begin
            pass = 1'b0;
        end
        if (f[11] && fc_new[14] != f[12]) begin
            pass = 1'b0;
        end
        // TKIP extended IV on a protected data frame
        if (f[0] && f[2:1] == FC_TYPE_DATA && f[11] && f[12] && ext_iv) begin
            pass = 1'b0;
        end
        if (i_cfg.bssid_filter != '0 && (!ok_b
                || fill_miss(cnt_new, offs.ob, 3'd6, i_cfg.bssid_filter))) begin
            pass = 1'b0;
        end
        if (i_cfg.source_filter != '0 && (!ok_s
                || fill_miss(cnt_new, offs.os, ns, i_cfg.source_filter))) begin
            pass = 1'b0;
        end
        if (i_cfg.dest_filter != '0 && (!ok_d
                || fill_miss(cnt_new, offs.od, nd, i_cfg.dest_filter))) begin
            pass = 1'b0;
        end
        cnt32 = 32'(cnt_new);

        n_count    = r_count;
        n_fc       = r_fc;
        n_bssid_ok = r_bssid_ok;
        n_src_ok   = r_src_ok;
        n_dst_ok   = r_dst_ok;
        n_ext_iv   = r_ext_iv;
        if (i_step) begin
            if (i_item.last_byte) begin
                n_count    = '0;
                n_fc       = '0;
                n_bssid_ok = 1'b1;
                n_src_ok   = 1'b1;
                n_dst_ok   = 1'b1;
                n_ext_iv   = 1'b0;
            end else begin
                n_count    = cnt_new;
                n_fc       = fc_new;
                n_bssid_ok = ok_b;
                n_src_ok   = ok_s;
                n_dst_ok   = ok_d;
                n_ext_iv   = ext_iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fc       <= '0;
            r_bssid_ok <= 1'b1;
            r_src_ok   <= 1'b1;
            r_dst_ok   <= 1'b1;
            r_ext_iv   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_fc       <= n_fc;
            r_bssid_ok <= n_bssid_ok;
            r_src_ok   <= n_src_ok;
            r_dst_ok   <= n_dst_ok;
            r_ext_iv   <= n_ext_iv;
        end
    end

    assign o_res_valid        = i_step && i_item.last_byte;
    assign o_res.pass         = pass;
    assign o_res.frame_length = cnt32[LEN_W-1:0];

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("byte count beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_count == '0 && r_bssid_ok && r_src_ok
            && r_dst_ok && !r_ext_iv)
        else $error("frame state not cleared after verdict");

    a_count_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.last_byte && r_count < CNT_MAX
            |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("byte count did not advance");

endmodule

// ----- src/wlan_frame_header_filter.sv -----
// 802.11 frame header filter.
// Input channel: one frame byte per request (frame_byte, last_byte), with
// i_in_valid / o_in_stall. Output channel: one verdict per frame (pass,
// frame_length), with o_out_valid / i_out_stall, issued for the request that
// carries last_byte. Other bytes produce no output.
// Configuration: plain write port (i_cfg_we, i_cfg_index, i_cfg_data); write
// only while no frame is in flight. Unknown indexes are dropped.
// Path: a last byte passes through two register stages, the input register
// and then the result register, before its verdict shows on o_out_valid.
// Throughput: one byte per cycle unless the receiver stalls; all per-byte
// compares and the verdict sit between the input and result registers.
// Reset (synchronous, active low) restores the register defaults and clears
// the frame state; no result is pending afterwards.
// When the receiver stalls a pending verdict, the byte in the input register
// holds and o_in_stall rises; the input side is held off only while both
// registers are occupied.
module wlan_frame_header_filter #(
    parameter int MAX_FRAME = wfhf_pkg::MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  wfhf_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output wfhf_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [wfhf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wfhf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wfhf_pkg::*;

    t_cfg cfg;
    logic r_in_valid, n_in_valid;
    t_in  r_in;
    logic r_out_valid, n_out_valid;
    t_out r_out;
    logic out_hold;
    logic stage_adv;
    logic in_take;
    logic res_valid;
    t_out res;

    wfhf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wfhf_hdr_track #(
        .MAX_FRAME (MAX_FRAME)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (stage_adv),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        out_hold    = r_out_valid && i_out_stall;
        stage_adv   = r_in_valid && !out_hold;
        o_in_stall  = r_in_valid && out_hold;
        in_take     = i_in_valid && !o_in_stall;
        n_in_valid  = in_take || (r_in_valid && out_hold);
        n_out_valid = out_hold || res_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (!out_hold) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_step_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hold |-> !stage_adv)
        else $error("byte processed while verdict held");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free stage");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled verdict changed");

endmodule
